>>> design/pcsp_pkg.sv
// ----------------------------------------------------------------------------
// pcsp_pkg
// Types, codes and tables shared by the PNG chunk stream parser.
// ----------------------------------------------------------------------------
package pcsp_pkg;

  // Byte kind codes
  localparam logic [3:0] KIND_SIG    = 4'd0;
  localparam logic [3:0] KIND_LEN    = 4'd1;
  localparam logic [3:0] KIND_TYPE   = 4'd2;
  localparam logic [3:0] KIND_KEY    = 4'd3;
  localparam logic [3:0] KIND_SEP    = 4'd4;
  localparam logic [3:0] KIND_TEXT   = 4'd5;
  localparam logic [3:0] KIND_METHOD = 4'd6;
  localparam logic [3:0] KIND_ZDATA  = 4'd7;
  localparam logic [3:0] KIND_TIME   = 4'd8;
  localparam logic [3:0] KIND_SKIP   = 4'd9;
  localparam logic [3:0] KIND_CRC    = 4'd10;
  localparam logic [3:0] KIND_NONE   = 4'd11;

  // Chunk class codes
  localparam logic [2:0] CLS_OTHER = 3'd0;
  localparam logic [2:0] CLS_TEXT  = 3'd1;
  localparam logic [2:0] CLS_ZTXT  = 3'd2;
  localparam logic [2:0] CLS_TIME  = 3'd3;
  localparam logic [2:0] CLS_IEND  = 3'd4;

  // Run status codes
  localparam logic [1:0] STAT_RUN  = 2'd0;
  localparam logic [1:0] STAT_DONE = 2'd1;
  localparam logic [1:0] STAT_ERR  = 2'd2;

  // Chunk type words, big-endian
  localparam logic [31:0] TYPE_TEXT = 32'h7445_5874;
  localparam logic [31:0] TYPE_ZTXT = 32'h7A54_5874;
  localparam logic [31:0] TYPE_TIME = 32'h7449_4D45;
  localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

  localparam logic [31:0] SIG_LEN       = 32'd8;
  localparam logic [31:0] FIELD_LEN     = 32'd4;
  localparam logic [31:0] TIME_LEN      = 32'd7;
  localparam logic [31:0] TIME_BUF_LAST = 32'd6;

  typedef enum logic [3:0] {
    PH_SIG, PH_LEN, PH_TYPE, PH_TKEY, PH_TVAL, PH_ZKEY, PH_ZMETH,
    PH_ZDATA, PH_TIME, PH_SKIP, PH_CRC, PH_HALT
  } phase_e;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  byte_kind;
    logic [7:0]  data_out;
    logic [2:0]  chunk_class;
    logic [1:0]  status;
    logic        time_valid;
    logic [15:0] year;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
  } out_item_t;

  // Parser state carried between items
  typedef struct packed {
    phase_e      phase;
    logic [31:0] phase_count;
    logic [31:0] chunk_length;
    logic [31:0] type_shift;
    logic [2:0]  current_class;
    logic [47:0] time_buffer;
    logic [1:0]  run_status;
  } pstate_t;

  // PNG file signature
  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0:    v = 8'h89;
      3'd1:    v = 8'h50;
      3'd2:    v = 8'h4e;
      3'd3:    v = 8'h47;
      3'd4:    v = 8'h0d;
      3'd5:    v = 8'h0a;
      3'd6:    v = 8'h1a;
      default: v = 8'h0a;
    endcase
    return v;
  endfunction

endpackage

>>> design/pcsp_step.sv
// ----------------------------------------------------------------------------
// pcsp_step
// Next-state and result logic for one byte of the chunk stream.
// ----------------------------------------------------------------------------
module pcsp_step (
  input  pcsp_pkg::pstate_t   cur_i,
  input  pcsp_pkg::in_item_t  item_i,
  output pcsp_pkg::pstate_t   nxt_o,
  output pcsp_pkg::out_item_t res_o
);
  import pcsp_pkg::*;

  logic [7:0]  b;
  logic [31:0] cnt_inc;
  logic [31:0] cnt_dec;
  logic [31:0] type_new;

  assign b        = item_i.byte_value;
  assign cnt_inc  = cur_i.phase_count + 32'd1;
  assign cnt_dec  = cur_i.phase_count - 32'd1;
  assign type_new = {cur_i.type_shift[23:0], b};

  // Phase walk
  always_comb begin
    nxt_o = cur_i;
    res_o = '0;
    res_o.byte_kind = KIND_NONE;
    if (cur_i.run_status != STAT_RUN || cur_i.phase == PH_HALT) begin
      // halted: nothing consumed
    end else if (item_i.end_of_input) begin
      nxt_o.run_status = STAT_ERR;
      nxt_o.phase      = PH_HALT;
    end else begin
      res_o.data_out = b;
      case (cur_i.phase)
        PH_SIG: begin
          res_o.byte_kind = KIND_SIG;
          if (b != sig_byte(cur_i.phase_count[2:0])) begin
            nxt_o.run_status = STAT_ERR;
            nxt_o.phase      = PH_HALT;
          end else begin
            nxt_o.phase_count = cnt_inc;
            if (cnt_inc >= SIG_LEN) begin
              nxt_o.phase        = PH_LEN;
              nxt_o.phase_count  = '0;
              nxt_o.chunk_length = '0;
            end
          end
        end
        PH_LEN: begin
          res_o.byte_kind    = KIND_LEN;
          nxt_o.chunk_length = {cur_i.chunk_length[23:0], b};
          nxt_o.phase_count  = cnt_inc;
          if (cnt_inc >= FIELD_LEN) begin
            nxt_o.phase       = PH_TYPE;
            nxt_o.phase_count = '0;
            nxt_o.type_shift  = '0;
          end
        end
        PH_TYPE: begin
          res_o.byte_kind   = KIND_TYPE;
          nxt_o.type_shift  = type_new;
          nxt_o.phase_count = cnt_inc;
          if (cnt_inc >= FIELD_LEN) begin
            // fourth type byte: classify and check the length
            nxt_o.phase_count = cur_i.chunk_length;
            if (type_new == TYPE_TEXT) begin
              nxt_o.current_class = CLS_TEXT;
              if (cur_i.chunk_length == '0) begin
                nxt_o.run_status = STAT_ERR;
                nxt_o.phase      = PH_HALT;
              end else begin
                nxt_o.phase = PH_TKEY;
              end
            end else if (type_new == TYPE_ZTXT) begin
              nxt_o.current_class = CLS_ZTXT;
              if (cur_i.chunk_length < 32'd2) begin
                nxt_o.run_status = STAT_ERR;
                nxt_o.phase      = PH_HALT;
              end else begin
                nxt_o.phase = PH_ZKEY;
              end
            end else if (type_new == TYPE_TIME) begin
              nxt_o.current_class = CLS_TIME;
              nxt_o.phase_count   = '0;
              nxt_o.time_buffer   = '0;
              if (cur_i.chunk_length != TIME_LEN) begin
                nxt_o.run_status = STAT_ERR;
                nxt_o.phase      = PH_HALT;
              end else begin
                nxt_o.phase = PH_TIME;
              end
            end else if (type_new == TYPE_IEND) begin
              nxt_o.current_class = CLS_IEND;
              nxt_o.run_status    = STAT_DONE;
              nxt_o.phase         = PH_HALT;
            end else begin
              nxt_o.current_class = CLS_OTHER;
              if (cur_i.chunk_length == '0) begin
                nxt_o.phase       = PH_CRC;
                nxt_o.phase_count = '0;
              end else begin
                nxt_o.phase = PH_SKIP;
              end
            end
          end
        end
        PH_TKEY, PH_ZKEY: begin
          nxt_o.phase_count = cnt_dec;
          if (b == 8'd0) begin
            res_o.byte_kind = KIND_SEP;
            if (cur_i.phase == PH_ZKEY) begin
              nxt_o.phase = PH_ZMETH;
            end else if (cnt_dec == '0) begin
              nxt_o.phase       = PH_CRC;
              nxt_o.phase_count = '0;
            end else begin
              nxt_o.phase = PH_TVAL;
            end
          end else begin
            res_o.byte_kind = KIND_KEY;
            // key must leave room for its terminator (and method for zTXt)
            if ((cur_i.phase == PH_ZKEY) ? (cnt_dec < 32'd2) : (cnt_dec == '0)) begin
              nxt_o.run_status = STAT_ERR;
              nxt_o.phase      = PH_HALT;
            end
          end
        end
        PH_ZMETH: begin
          res_o.byte_kind   = KIND_METHOD;
          nxt_o.phase_count = cnt_dec;
          if (b != 8'd0) begin
            nxt_o.run_status = STAT_ERR;
            nxt_o.phase      = PH_HALT;
          end else if (cnt_dec == '0) begin
            nxt_o.phase       = PH_CRC;
            nxt_o.phase_count = '0;
          end else begin
            nxt_o.phase = PH_ZDATA;
          end
        end
        PH_TVAL, PH_ZDATA, PH_SKIP: begin
          res_o.byte_kind = (cur_i.phase == PH_TVAL)  ? KIND_TEXT  :
                            (cur_i.phase == PH_ZDATA) ? KIND_ZDATA : KIND_SKIP;
          nxt_o.phase_count = cnt_dec;
          if (cnt_dec == '0) begin
            nxt_o.phase       = PH_CRC;
            nxt_o.phase_count = '0;
          end
        end
        PH_TIME: begin
          res_o.byte_kind = KIND_TIME;
          if (cur_i.phase_count >= TIME_BUF_LAST) begin
            res_o.time_valid  = 1'b1;
            res_o.year        = cur_i.time_buffer[47:32];
            res_o.month       = cur_i.time_buffer[31:24];
            res_o.day         = cur_i.time_buffer[23:16];
            res_o.hour        = cur_i.time_buffer[15:8];
            res_o.minute      = cur_i.time_buffer[7:0];
            res_o.second      = b;
            nxt_o.phase       = PH_CRC;
            nxt_o.phase_count = '0;
          end else begin
            nxt_o.time_buffer = {cur_i.time_buffer[39:0], b};
            nxt_o.phase_count = cnt_inc;
          end
        end
        PH_CRC: begin
          res_o.byte_kind   = KIND_CRC;
          nxt_o.phase_count = cnt_inc;
          if (cnt_inc >= FIELD_LEN) begin
            nxt_o.phase         = PH_LEN;
            nxt_o.phase_count   = '0;
            nxt_o.chunk_length  = '0;
            nxt_o.current_class = CLS_OTHER;
          end
        end
        default: begin
          nxt_o.run_status = STAT_ERR;
          nxt_o.phase      = PH_HALT;
        end
      endcase
    end
    res_o.chunk_class = nxt_o.current_class;
    res_o.status      = nxt_o.run_status;
  end

endmodule

>>> design/png_chunk_stream_parser_core.sv
// ----------------------------------------------------------------------------
// png_chunk_stream_parser_core
// Byte-wise PNG chunk walker: tags each byte, extracts tIME, halts on error.
// ----------------------------------------------------------------------------
// Path: an accepted item goes through the input register, then the step logic
//   into the result register; output back-pressure can hold it in between.
// Throughput: one item per cycle, limited only by output back-pressure.
// Reset (rst_ni low, asynchronous): both stages empty, parser back in the
//   signature phase with status running. No clearing pass.
module png_chunk_stream_parser_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pcsp_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pcsp_pkg::out_item_t out_item_o
);
  import pcsp_pkg::*;

  logic      in_valid_q;
  in_item_t  in_q;
  logic      out_valid_q;
  out_item_t out_q;
  pstate_t   state_q;
  pstate_t   state_d;
  out_item_t res_d;
  logic      out_free;
  logic      advance;

  // Stage handshakes
  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_item_i;
    end
  end

  // Step logic
  pcsp_step u_step (
    .cur_i  (state_q),
    .item_i (in_q),
    .nxt_o  (state_d),
    .res_o  (res_d)
  );

  // Parser state, updated as each item moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase         <= PH_SIG;
      state_q.phase_count   <= '0;
      state_q.chunk_length  <= '0;
      state_q.type_shift    <= '0;
      state_q.current_class <= CLS_OTHER;
      state_q.time_buffer   <= '0;
      state_q.run_status    <= STAT_RUN;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Checks
  a_halt_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.run_status != STAT_RUN |-> state_q.phase == PH_HALT)
    else $error("halted status without halt phase");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.run_status != STAT_RUN |=> $stable(state_q))
    else $error("state changed after halt");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.byte_kind == KIND_NONE |-> out_q.data_out == 8'd0)
    else $error("data on an item with no byte consumed");

  a_time_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.time_valid |-> out_q.byte_kind == KIND_TIME
      && out_q.chunk_class == CLS_TIME)
    else $error("time fields outside a tIME byte");

  a_iend_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.chunk_class == CLS_IEND |-> out_q.status == STAT_DONE)
    else $error("IEND class without finished status");

endmodule

>>> verif/pcsp_sb_pkg.sv
// ----------------------------------------------------------------------------
// pcsp_sb_pkg
// Scoreboard for the PNG chunk stream parser: it tracks the parse of every
// accepted byte, predicts its tag, chunk class, status and tIME fields, and
// compares each delivered result with the oldest prediction.
// ----------------------------------------------------------------------------
package pcsp_sb_pkg;

  import pcsp_pkg::*;

  // PNG file signature, first byte in the top lane
  localparam logic [63:0] PNG_MAGIC  = 64'h8950_4E47_0D0A_1A0A;
  // Stop printing after this many reports, keep counting
  localparam int          REPORT_CAP = 100;

  class parse_scoreboard;

    // Predicted parser state
    phase_e      ph;
    logic [31:0] cnt;
    logic [31:0] len;
    logic [31:0] tshift;
    logic [2:0]  cls;
    logic [47:0] tbuf;
    logic [1:0]  rstat;

    out_item_t   expected_tags[$];
    int          errors;

    function new();
      ph     = PH_SIG;
      cnt    = '0;
      len    = '0;
      tshift = '0;
      cls    = CLS_OTHER;
      tbuf   = '0;
      rstat  = STAT_RUN;
      errors = 0;
    endfunction

    function int pending();
      return expected_tags.size();
    endfunction

    function void halt_on_error();
      rstat = STAT_ERR;
      ph    = PH_HALT;
    endfunction

    function void enter_crc();
      ph  = PH_CRC;
      cnt = '0;
    endfunction

    // Fourth type byte seen: classify the chunk and pick the data phase
    function void open_chunk_data();
      cnt = len;
      case (tshift)
        TYPE_TEXT: begin
          cls = CLS_TEXT;
          if (len == 0) halt_on_error(); else ph = PH_TKEY;
        end
        TYPE_ZTXT: begin
          cls = CLS_ZTXT;
          if (len < 2) halt_on_error(); else ph = PH_ZKEY;
        end
        TYPE_TIME: begin
          cls  = CLS_TIME;
          cnt  = '0;
          tbuf = '0;
          if (len != TIME_LEN) halt_on_error(); else ph = PH_TIME;
        end
        TYPE_IEND: begin
          cls   = CLS_IEND;
          rstat = STAT_DONE;
          ph    = PH_HALT;
        end
        default: begin
          cls = CLS_OTHER;
          if (len == 0) enter_crc(); else ph = PH_SKIP;
        end
      endcase
    endfunction

    // One byte through the parser: returns its tag and updates the state
    function out_item_t parse_byte(in_item_t it);
      out_item_t  r;
      logic [7:0] b;
      r           = '0;
      r.byte_kind = KIND_NONE;
      b           = it.byte_value;
      if (rstat != STAT_RUN || ph == PH_HALT) begin
        // halted: nothing consumed, nothing changes
      end else if (it.end_of_input) begin
        halt_on_error();
      end else begin
        r.data_out = b;
        case (ph)
          PH_SIG: begin
            r.byte_kind = KIND_SIG;
            if (b != PNG_MAGIC[8 * (7 - int'(cnt[2:0])) +: 8]) begin
              halt_on_error();
            end else begin
              cnt = cnt + 1;
              if (cnt >= SIG_LEN) begin
                ph  = PH_LEN;
                cnt = '0;
                len = '0;
              end
            end
          end
          PH_LEN: begin
            r.byte_kind = KIND_LEN;
            len = {len[23:0], b};
            cnt = cnt + 1;
            if (cnt >= FIELD_LEN) begin
              ph     = PH_TYPE;
              cnt    = '0;
              tshift = '0;
            end
          end
          PH_TYPE: begin
            r.byte_kind = KIND_TYPE;
            tshift = {tshift[23:0], b};
            cnt    = cnt + 1;
            if (cnt >= FIELD_LEN) open_chunk_data();
          end
          PH_TKEY, PH_ZKEY: begin
            cnt = cnt - 1;
            if (b == 8'h00) begin
              r.byte_kind = KIND_SEP;
              if (ph == PH_ZKEY) ph = PH_ZMETH;
              else if (cnt == 0) enter_crc();
              else ph = PH_TVAL;
            end else begin
              r.byte_kind = KIND_KEY;
              // zTXt must keep room for the method byte
              if ((ph == PH_ZKEY) ? (cnt < 2) : (cnt == 0)) halt_on_error();
            end
          end
          PH_ZMETH: begin
            r.byte_kind = KIND_METHOD;
            cnt = cnt - 1;
            if (b != 8'h00) halt_on_error();
            else if (cnt == 0) enter_crc();
            else ph = PH_ZDATA;
          end
          PH_TVAL, PH_ZDATA, PH_SKIP: begin
            r.byte_kind = (ph == PH_TVAL)  ? KIND_TEXT :
                          (ph == PH_ZDATA) ? KIND_ZDATA : KIND_SKIP;
            cnt = cnt - 1;
            if (cnt == 0) enter_crc();
          end
          PH_TIME: begin
            r.byte_kind = KIND_TIME;
            if (cnt >= TIME_BUF_LAST) begin
              r.time_valid = 1'b1;
              r.year       = tbuf[47:32];
              r.month      = tbuf[31:24];
              r.day        = tbuf[23:16];
              r.hour       = tbuf[15:8];
              r.minute     = tbuf[7:0];
              r.second     = b;
              enter_crc();
            end else begin
              tbuf = {tbuf[39:0], b};
              cnt  = cnt + 1;
            end
          end
          PH_CRC: begin
            r.byte_kind = KIND_CRC;
            cnt = cnt + 1;
            if (cnt >= FIELD_LEN) begin
              ph  = PH_LEN;
              cnt = '0;
              len = '0;
              cls = CLS_OTHER;
            end
          end
          default: halt_on_error();
        endcase
      end
      r.chunk_class = cls;
      r.status      = rstat;
      return r;
    endfunction

    function void note_byte(in_item_t it);
      expected_tags.push_back(parse_byte(it));
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                   $time, name, want, got);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_tags.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: unexpected result: expected none, actual %p", $time, got);
        return;
      end
      want = expected_tags.pop_front();
      compare_field("byte_kind",   16'(want.byte_kind),   16'(got.byte_kind));
      compare_field("data_out",    16'(want.data_out),    16'(got.data_out));
      compare_field("chunk_class", 16'(want.chunk_class), 16'(got.chunk_class));
      compare_field("status",      16'(want.status),      16'(got.status));
      compare_field("time_valid",  16'(want.time_valid),  16'(got.time_valid));
      compare_field("year",        want.year,             got.year);
      compare_field("month",       16'(want.month),       16'(got.month));
      compare_field("day",         16'(want.day),         16'(got.day));
      compare_field("hour",        16'(want.hour),        16'(got.hour));
      compare_field("minute",      16'(want.minute),      16'(got.minute));
      compare_field("second",      16'(want.second),      16'(got.second));
    endfunction

  endclass

endpackage

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for png_chunk_stream_parser_core. Builds one PNG byte stream
// (signature, a tIME chunk with extreme fields, then random tEXt, zTXt, tIME
// and other chunks) closed by a randomly chosen ending: IEND, end of input,
// or one of the error cases, followed by bytes sent to the halted parser.
// Bytes go in bursts, results are taken with a changing stall pattern, and
// every result is checked against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  import pcsp_pkg::*;
  import pcsp_sb_pkg::*;

  // Ways the stream may end
  typedef enum int {
    END_IEND, END_EOI, END_TEXT_EMPTY, END_ZTXT_SHORT, END_TIME_LEN,
    END_TKEY_OPEN, END_ZKEY_OPEN, END_ZMETH_BAD, END_HUGE
  } stream_end_e;

  // Receiver stall patterns
  typedef enum int {RDY_FULL, RDY_MOSTLY, RDY_RARELY, RDY_PERIODIC} ready_mode_e;

  localparam int STREAM_BYTES = 1300;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  parse_scoreboard sb = new();

  in_item_t   byte_stream[$];
  logic [7:0] chunk_body[$];

  ready_mode_e rdy_mode  = RDY_FULL;
  int unsigned rdy_left  = 0;
  int unsigned rdy_tick  = 0;

  png_chunk_stream_parser_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always #10 clk_i = ~clk_i;

  // Stream building
  task automatic put_item(logic [7:0] b, logic eoi);
    in_item_t it;
    it.byte_value   = b;
    it.end_of_input = eoi;
    byte_stream.push_back(it);
  endtask

  task automatic put_word(logic [31:0] w);
    for (int k = 3; k >= 0; k--) put_item(w[8 * k +: 8], 1'b0);
  endtask

  task automatic add_key(int n);
    repeat (n) chunk_body.push_back(8'($urandom_range(1, 255)));
  endtask

  task automatic add_any(int n);
    repeat (n) chunk_body.push_back(8'($urandom_range(0, 255)));
  endtask

  // Length, type, the prepared body and a random CRC
  task automatic put_chunk(logic [31:0] ctype, logic [31:0] clen);
    put_word(clen);
    put_word(ctype);
    foreach (chunk_body[k]) put_item(chunk_body[k], 1'b0);
    put_word($urandom);
    chunk_body.delete();
  endtask

  task automatic put_random_chunk();
    logic [31:0] known[4];
    logic [31:0] ctype;
    int          sel;
    known = '{TYPE_TEXT, TYPE_ZTXT, TYPE_TIME, TYPE_IEND};
    sel   = $urandom_range(0, 9);
    chunk_body.delete();
    case (sel)
      0, 1, 2: begin
        add_key($urandom_range(0, 8));
        chunk_body.push_back(8'h00);
        add_any(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
        ctype = TYPE_TEXT;
      end
      3, 4: begin
        add_key($urandom_range(0, 8));
        chunk_body.push_back(8'h00);
        chunk_body.push_back(8'h00);
        add_any(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
        ctype = TYPE_ZTXT;
      end
      5: begin
        repeat (7) begin
          if ($urandom_range(0, 2) == 0)
            chunk_body.push_back($urandom_range(0, 1) ? 8'hFF : 8'h00);
          else
            chunk_body.push_back(8'($urandom_range(0, 255)));
        end
        ctype = TYPE_TIME;
      end
      6, 7: begin
        add_any(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20));
        ctype = $urandom;
      end
      8: begin
        // one bit away from a known type
        add_any($urandom_range(0, 10));
        ctype = known[$urandom_range(0, 3)] ^ (32'h1 << $urandom_range(0, 31));
      end
      default: ctype = $urandom;
    endcase
    put_chunk(ctype, chunk_body.size());
  endtask

  // Receiver stall pattern
  always @(posedge clk_i) begin
    rdy_tick <= rdy_tick + 1;
    if (rdy_left == 0) begin
      rdy_mode <= ready_mode_e'($urandom_range(0, 3));
      rdy_left <= $urandom_range(32, 256);
    end else begin
      rdy_left <= rdy_left - 1;
    end
    case (rdy_mode)
      RDY_FULL:   out_ready_i <= 1'b1;
      RDY_MOSTLY: out_ready_i <= ($urandom_range(0, 3) != 0);
      RDY_RARELY: out_ready_i <= ($urandom_range(0, 3) == 0);
      default:    out_ready_i <= ((rdy_tick % 7) < 4);
    endcase
  end

  // Accepted items in, delivered results checked
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_byte(in_item_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_item_o);
    end
  end

  initial begin
    stream_end_e ending;
    logic [31:0] bad_len;
    int          bad_pos;
    int          cut;
    int          burst;
    int          hold_at;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Signature, one byte possibly corrupted
    bad_pos = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 7) : -1;
    for (int k = 0; k < 8; k++) begin
      if (k == bad_pos)
        put_item(PNG_MAGIC[8 * (7 - k) +: 8] ^ 8'($urandom_range(1, 255)), 1'b0);
      else
        put_item(PNG_MAGIC[8 * (7 - k) +: 8], 1'b0);
    end

    if (bad_pos < 0) begin
      // tIME with extreme field values
      chunk_body = '{8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00};
      put_chunk(TYPE_TIME, TIME_LEN);

      while (byte_stream.size() < STREAM_BYTES) put_random_chunk();

      ending = stream_end_e'($urandom_range(0, END_HUGE));
      case (ending)
        END_IEND: put_chunk(TYPE_IEND, 32'd0);
        END_EOI: begin
          // input runs dry inside a chunk or at a chunk boundary
          put_random_chunk();
          cut = $urandom_range(0, 12);
          repeat (cut) void'(byte_stream.pop_back());
          put_item(8'($urandom_range(0, 255)), 1'b1);
        end
        END_TEXT_EMPTY: put_chunk(TYPE_TEXT, 32'd0);
        END_ZTXT_SHORT: begin
          add_key(1);
          put_chunk(TYPE_ZTXT, $urandom_range(0, 1));
        end
        END_TIME_LEN: begin
          case ($urandom_range(0, 3))
            0:       bad_len = $urandom_range(0, 6);
            1:       bad_len = $urandom_range(8, 255);
            2:       bad_len = 32'h0000_0107;
            default: bad_len = 32'h8000_0007;
          endcase
          add_any(7);
          put_chunk(TYPE_TIME, bad_len);
        end
        END_TKEY_OPEN: begin
          add_key($urandom_range(1, 5));
          put_chunk(TYPE_TEXT, chunk_body.size());
        end
        END_ZKEY_OPEN: begin
          add_key($urandom_range(2, 5));
          put_chunk(TYPE_ZTXT, chunk_body.size());
        end
        END_ZMETH_BAD: begin
          add_key($urandom_range(0, 3));
          chunk_body.push_back(8'h00);
          chunk_body.push_back(8'($urandom_range(1, 255)));
          add_any($urandom_range(0, 4));
          put_chunk(TYPE_ZTXT, chunk_body.size());
        end
        default: begin
          // length with high bytes set, cut short by end of input
          add_any($urandom_range(1, 16));
          put_chunk($urandom, {8'($urandom_range(1, 255)), 24'($urandom)});
          put_item(8'($urandom_range(0, 255)), 1'b1);
        end
      endcase
    end

    // Bytes for the halted parser, end of input among them
    put_item(8'($urandom_range(0, 255)), 1'b1);
    repeat ($urandom_range(5, 11))
      put_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    // a stream stopped at the signature still gets a full-length run
    while (byte_stream.size() < STREAM_BYTES)
      put_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

    // Send in bursts; halfway through, wait for the results to drain
    burst   = $urandom_range(1, 60);
    hold_at = byte_stream.size() / 2;
    foreach (byte_stream[i]) begin
      if (i == hold_at) begin
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (sb.pending() != 0);
      end
      in_valid_i <= 1'b1;
      in_item_i  <= byte_stream[i];
      do @(posedge clk_i); while (!in_ready_o);
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 60);
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;

    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (8) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
